// ===== rtl/drts_pkg.sv =====
// ----------------------------------------------------------------------------
// drts_pkg
// Shared types and constants for the record TTL scanner.
// ----------------------------------------------------------------------------
`default_nettype none
package drts_pkg;

	localparam int unsigned HEADER_BYTES = 12;
	localparam logic [15:0] TYPE_OPT = 16'd41;
	localparam logic [17:0] SEEN_MAX = 18'h3FFFF;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_ZERO = 2'd3;

	// configuration register indexes
	localparam logic [0:0] REG_MODE = 1'b0;
	localparam logic [0:0] REG_TTL = 1'b1;

	// parser phases, one-hot
	typedef enum logic [11:0] {
		PH_HDR     = 12'b0000_0000_0001,
		PH_Q_LEN   = 12'b0000_0000_0010,
		PH_Q_LABEL = 12'b0000_0000_0100,
		PH_Q_PTR   = 12'b0000_0000_1000,
		PH_Q_FIX   = 12'b0000_0001_0000,
		PH_R_LEN   = 12'b0000_0010_0000,
		PH_R_LABEL = 12'b0000_0100_0000,
		PH_R_PTR   = 12'b0000_1000_0000,
		PH_R_FIX   = 12'b0001_0000_0000,
		PH_R_DATA  = 12'b0010_0000_0000,
		PH_TRAIL   = 12'b0100_0000_0000,
		PH_ERR     = 12'b1000_0000_0000
	} phase_t;

	// one classified beat between front and back
	typedef struct packed {
		logic        is_sum;
		logic [7:0]  byte_v;
		logic [1:0]  status;
		logic [31:0] min_ttl;
		logic [17:0] count;
	} beat_t;

endpackage
`default_nettype wire

// ===== rtl/drts_front.sv =====
// ----------------------------------------------------------------------------
// drts_front
// Byte parser: walks header, questions and records, rewrites TTL bytes in scan mode and
// pushes one beat per byte plus a summary beat after the last byte.
// ----------------------------------------------------------------------------
`default_nettype none
module drts_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              is_last_in,
	input  wire logic              scan_mode,
	input  wire logic [31:0]       replacement_ttl,
	output      logic              push,
	output      drts_pkg::beat_t   push_beat,
	input  wire logic [1:0]        space
);

	drts_pkg::phase_t phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [15:0] q_left_q, q_left_d, an_left_q, an_left_d;
	logic [15:0] au_left_q, au_left_d, ad_left_q, ad_left_d;
	logic [5:0]  lab_q, lab_d;
	logic [15:0] rd_q, rd_d, rtype_q, rtype_d;
	logic [31:0] shift_q, shift_d, least_q, least_d;
	logic [17:0] seen_q, seen_d;
	logic        err_q, err_d;
	logic        pend_q;         // summary still owed for last byte
	logic [1:0]  sum_st_q;
	logic [31:0] sum_min_q;
	logic [17:0] sum_cnt_q;
	logic [7:0]  ob;
	logic        take;
	logic [1:0]  st;

	// a byte (and possibly its summary) needs two free slots
	assign in_ready = !pend_q && (space == 2'd2);
	assign take = in_valid && in_ready;

	// next-state parse logic
	always_comb begin
		logic [15:0] an_t, au_t, ad_t;
		phase_d = phase_q; idx_d = idx_q; q_left_d = q_left_q; an_left_d = an_left_q;
		au_left_d = au_left_q; ad_left_d = ad_left_q; lab_d = lab_q; rd_d = rd_q;
		rtype_d = rtype_q; shift_d = shift_q; least_d = least_q; seen_d = seen_q;
		err_d = err_q; ob = data_byte;
		an_t = an_left_q; au_t = au_left_q; ad_t = ad_left_q;
		case (phase_q)
			drts_pkg::PH_HDR: begin
				if (idx_q == 4'd4 || idx_q == 4'd5) q_left_d = {q_left_q[7:0], data_byte};
				else if (idx_q == 4'd6 || idx_q == 4'd7) an_left_d = {an_left_q[7:0], data_byte};
				else if (idx_q == 4'd8 || idx_q == 4'd9)
					au_left_d = scan_mode ? {au_left_q[7:0], data_byte} : 16'd0;
				else if (idx_q == 4'd10 || idx_q == 4'd11)
					ad_left_d = scan_mode ? {ad_left_q[7:0], data_byte} : 16'd0;
				if (idx_q >= 4'(drts_pkg::HEADER_BYTES - 1)) begin
					idx_d = '0;
					if (q_left_q != 16'd0) phase_d = drts_pkg::PH_Q_LEN;
					else if (an_left_q != 0 || au_left_q != 0 || ad_left_d != 0)
						phase_d = drts_pkg::PH_R_LEN;
					else phase_d = drts_pkg::PH_TRAIL;
				end else idx_d = idx_q + 4'd1;
			end
			drts_pkg::PH_Q_LEN, drts_pkg::PH_R_LEN: begin
				if (data_byte[7:6] == 2'b11)
					phase_d = (phase_q == drts_pkg::PH_Q_LEN) ? drts_pkg::PH_Q_PTR : drts_pkg::PH_R_PTR;
				else if (data_byte[7:6] != 2'b00) begin
					err_d = 1'b1; phase_d = drts_pkg::PH_ERR;
				end else if (data_byte == 8'd0) begin
					idx_d = '0;
					phase_d = (phase_q == drts_pkg::PH_Q_LEN) ? drts_pkg::PH_Q_FIX : drts_pkg::PH_R_FIX;
				end else begin
					lab_d = data_byte[5:0];
					phase_d = (phase_q == drts_pkg::PH_Q_LEN) ? drts_pkg::PH_Q_LABEL : drts_pkg::PH_R_LABEL;
				end
			end
			drts_pkg::PH_Q_LABEL, drts_pkg::PH_R_LABEL: begin
				if (lab_q != 6'd0) lab_d = lab_q - 6'd1;
				if (lab_q <= 6'd1)
					phase_d = (phase_q == drts_pkg::PH_Q_LABEL) ? drts_pkg::PH_Q_LEN : drts_pkg::PH_R_LEN;
			end
			drts_pkg::PH_Q_PTR: begin idx_d = '0; phase_d = drts_pkg::PH_Q_FIX; end
			drts_pkg::PH_R_PTR: begin idx_d = '0; phase_d = drts_pkg::PH_R_FIX; end
			drts_pkg::PH_Q_FIX: begin
				if (idx_q >= 4'd3) begin
					idx_d = '0;
					q_left_d = (q_left_q != 0) ? q_left_q - 16'd1 : q_left_q;
					if (q_left_d != 16'd0) phase_d = drts_pkg::PH_Q_LEN;
					else if (an_left_q != 0 || au_left_q != 0 || ad_left_q != 0)
						phase_d = drts_pkg::PH_R_LEN;
					else phase_d = drts_pkg::PH_TRAIL;
				end else idx_d = idx_q + 4'd1;
			end
			drts_pkg::PH_R_FIX, drts_pkg::PH_R_DATA: begin
				logic done;
				done = 1'b0;
				if (phase_q == drts_pkg::PH_R_FIX) begin
					if (idx_q <= 4'd1) rtype_d = {rtype_q[7:0], data_byte};
					else if (idx_q >= 4'd4 && idx_q <= 4'd7) begin
						shift_d = {shift_q[23:0], data_byte};
						if (rtype_q != drts_pkg::TYPE_OPT) begin
							if (scan_mode) ob = replacement_ttl[8*(2'd3-idx_q[1:0]) +: 8];
							if (idx_q == 4'd7) begin
								if (seen_q < drts_pkg::SEEN_MAX) seen_d = seen_q + 18'd1;
								if (shift_d < least_q) least_d = shift_d;
							end
						end
					end else if (idx_q >= 4'd8) rd_d = {rd_q[7:0], data_byte};
					if (idx_q >= 4'd9) begin
						idx_d = '0;
						if (rd_d == 16'd0) done = 1'b1;
						else phase_d = drts_pkg::PH_R_DATA;
					end else idx_d = idx_q + 4'd1;
				end else begin
					if (rd_q != 0) rd_d = rd_q - 16'd1;
					if (rd_q <= 16'd1) done = 1'b1;
				end
				if (done) begin
					idx_d = '0;
					if (an_left_q != 0) an_t = an_left_q - 16'd1;
					else if (au_left_q != 0) au_t = au_left_q - 16'd1;
					else if (ad_left_q != 0) ad_t = ad_left_q - 16'd1;
					an_left_d = an_t; au_left_d = au_t; ad_left_d = ad_t;
					if (q_left_q != 0) phase_d = drts_pkg::PH_Q_LEN;
					else if (an_t != 0 || au_t != 0 || ad_t != 0) phase_d = drts_pkg::PH_R_LEN;
					else phase_d = drts_pkg::PH_TRAIL;
				end
			end
			drts_pkg::PH_TRAIL: ;
			default: phase_d = drts_pkg::PH_ERR;
		endcase
	end

	// summary status from the post-byte state
	always_comb begin
		if (err_d || phase_d != drts_pkg::PH_TRAIL) st = drts_pkg::ST_BAD;
		else if (scan_mode) st = drts_pkg::ST_OK;
		else if (seen_d == 18'd0) st = drts_pkg::ST_NONE;
		else if (least_d == 32'd0) st = drts_pkg::ST_ZERO;
		else st = drts_pkg::ST_OK;
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= drts_pkg::PH_HDR; idx_q <= '0; q_left_q <= '0; an_left_q <= '0;
			au_left_q <= '0; ad_left_q <= '0; lab_q <= '0; rd_q <= '0; rtype_q <= '0;
			shift_q <= '0; least_q <= '1; seen_q <= '0; err_q <= 1'b0; pend_q <= 1'b0;
		end else if (take && is_last_in) begin
			phase_q <= drts_pkg::PH_HDR; idx_q <= '0; q_left_q <= '0; an_left_q <= '0;
			au_left_q <= '0; ad_left_q <= '0; lab_q <= '0; rd_q <= '0; rtype_q <= '0;
			shift_q <= '0; least_q <= '1; seen_q <= '0; err_q <= 1'b0; pend_q <= 1'b1;
		end else begin
			if (take) begin
				phase_q <= phase_d; idx_q <= idx_d; q_left_q <= q_left_d;
				an_left_q <= an_left_d; au_left_q <= au_left_d; ad_left_q <= ad_left_d;
				lab_q <= lab_d; rd_q <= rd_d; rtype_q <= rtype_d; shift_q <= shift_d;
				least_q <= least_d; seen_q <= seen_d; err_q <= err_d;
			end
			pend_q <= 1'b0;
		end
	end

	// held summary payload
	always_ff @(posedge clk) begin
		if (take && is_last_in) begin
			sum_st_q <= st; sum_min_q <= least_d; sum_cnt_q <= seen_d;
		end
	end

	// push byte beat, then summary beat on the following cycle
	always_comb begin
		push = take || pend_q;
		push_beat = '0;
		if (pend_q) begin
			push_beat.is_sum = 1'b1; push_beat.status = sum_st_q;
			push_beat.min_ttl = sum_min_q; push_beat.count = sum_cnt_q;
		end else push_beat.byte_v = ob;
	end

endmodule
`default_nettype wire

// ===== rtl/drts_fifo.sv =====
// ----------------------------------------------------------------------------
// drts_fifo
// Four-entry beat queue parting the parser from the output side.
// ----------------------------------------------------------------------------
`default_nettype none
module drts_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire drts_pkg::beat_t push_beat,
	output      logic [1:0]      space,
	output      logic            out_valid,
	input  wire logic            pop,
	output      drts_pkg::beat_t head
);

	drts_pkg::beat_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign out_valid = cnt_q != 3'd0;
	assign head = mem_q[rp_q];
	// free slots, saturated at two (counts pending summary slot)
	assign space = (cnt_q <= 3'd2) ? 2'd2 : ((cnt_q == 3'd3) ? 2'd1 : 2'd0);

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_beat;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop && out_valid) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop && out_valid);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dns_record_ttl_scanner.sv =====
// a byte beat enters the beat queue in the cycle it is accepted, its summary beat
// in the next cycle; throughput: one byte per cycle while two queue slots are free
// and no summary beat is owed; the summary takes the single queue write port
// the four-entry beat queue lets input run while output stalls
// reset: arst_n clears parser, queue and registers (mode 0, ttl 0)
// ----------------------------------------------------------------------------
// dns_record_ttl_scanner
// Streams message bytes, rewrites or collects record TTLs, adds a summary.
// ----------------------------------------------------------------------------
`default_nettype none
module dns_record_ttl_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last_in,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        item_kind,
	output      logic [7:0]  out_byte,
	output      logic [1:0]  status,
	output      logic [31:0] min_ttl,
	output      logic [17:0] ttl_count,
	output      logic        is_last_out
);

	logic            mode_q;
	logic [31:0]     rttl_q;
	logic            push;
	logic [1:0]      space;
	drts_pkg::beat_t push_beat, head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0; rttl_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				drts_pkg::REG_MODE: mode_q <= cfg_data[0];
				drts_pkg::REG_TTL: rttl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	drts_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .is_last_in(is_last_in), .scan_mode(mode_q),
		.replacement_ttl(rttl_q), .push(push), .push_beat(push_beat), .space(space)
	);

	drts_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_beat(push_beat), .space(space),
		.out_valid(out_valid), .pop(out_ready), .head(head)
	);

	// output fields
	assign item_kind = head.is_sum;
	assign out_byte = head.byte_v;
	assign status = head.status;
	assign min_ttl = head.min_ttl;
	assign ttl_count = head.count;
	assign is_last_out = head.is_sum;

endmodule
`default_nettype wire

// ===== rtl/drts_checker.sv =====
// ----------------------------------------------------------------------------
// drts_checker
// Port-level checks on the scanner output stream.
// ----------------------------------------------------------------------------
`default_nettype none
module drts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        item_kind,
	input wire logic        is_last_out,
	input wire logic [7:0]  out_byte,
	input wire logic [1:0]  status
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("output beat changed under stall");

	// summary and last mark agree
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> item_kind == is_last_out)
		else $error("last mark mismatch");

	// byte beats carry no status
	a_bst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !item_kind |-> status == 2'd0)
		else $error("status on byte beat");

	// summary carries no byte
	a_sb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind |-> out_byte == 8'd0)
		else $error("byte on summary beat");

endmodule

bind dns_record_ttl_scanner drts_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.item_kind(item_kind), .is_last_out(is_last_out), .out_byte(out_byte), .status(status)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams DNS messages into the TTL scanner, predicts every byte and summary
// beat with a behavioural parser and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_beat_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [1:0]  st;
		logic [31:0] least;
		logic [17:0] cnt;
		logic        last;
	} scan_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = drts_pkg::REG_MODE;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        is_last_in = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        item_kind;
	logic [7:0]  out_byte;
	logic [1:0]  status;
	logic [31:0] min_ttl;
	logic [17:0] ttl_count;
	logic        is_last_out;

	dns_record_ttl_scanner u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.is_last_in(is_last_in),
		.out_valid(out_valid), .out_ready(out_ready), .item_kind(item_kind),
		.out_byte(out_byte), .status(status), .min_ttl(min_ttl),
		.ttl_count(ttl_count), .is_last_out(is_last_out)
	);

	always #5 clk = ~clk;

	// stimulus and expectations
	byte_beat_t pending_bytes[$];
	scan_beat_t expected_beats[$];
	int         mismatch_count = 0;
	int         stray_count = 0;
	longint     cycle_count = 0;
	bit         stall_hold = 1'b0;
	bit         feed_done = 1'b0;

	// predictor state
	drts_pkg::phase_t ph;
	logic [3:0]  fidx;
	logic [15:0] q_left, an_left, au_left, ad_left, rd_left, rtype;
	logic [5:0]  lab_left;
	logic [31:0] ttl_acc, least_ttl;
	logic [17:0] seen;
	logic        err;
	logic        mode_reg = 1'b0;
	logic [31:0] repl_ttl = '0;

	function automatic void clear_parser();
		ph = drts_pkg::PH_HDR; fidx = 0; q_left = 0; an_left = 0; au_left = 0; ad_left = 0;
		lab_left = 0; rd_left = 0; rtype = 0; ttl_acc = 0; least_ttl = '1;
		seen = 0; err = 0;
	endfunction

	function automatic void pick_section();
		fidx = 0;
		if (q_left != 0) ph = drts_pkg::PH_Q_LEN;
		else if (an_left != 0 || au_left != 0 || ad_left != 0) ph = drts_pkg::PH_R_LEN;
		else ph = drts_pkg::PH_TRAIL;
	endfunction

	function automatic void close_record();
		if (an_left != 0) an_left--;
		else if (au_left != 0) au_left--;
		else if (ad_left != 0) ad_left--;
		pick_section();
	endfunction

	function automatic void name_byte(logic [7:0] b, bit in_q);
		if (b[7:6] == 2'b11) ph = in_q ? drts_pkg::PH_Q_PTR : drts_pkg::PH_R_PTR;
		else if (b[7:6] != 2'b00) begin
			err = 1; ph = drts_pkg::PH_ERR;
		end else if (b == 0) begin
			fidx = 0; ph = in_q ? drts_pkg::PH_Q_FIX : drts_pkg::PH_R_FIX;
		end else begin
			lab_left = b[5:0]; ph = in_q ? drts_pkg::PH_Q_LABEL : drts_pkg::PH_R_LABEL;
		end
	endfunction

	// advance the parser by one byte and queue the beats it causes
	function automatic void predict_byte(logic [7:0] b, logic last);
		logic [7:0] ob;
		scan_beat_t e;
		ob = b;
		case (ph)
			drts_pkg::PH_HDR: begin
				if (fidx == 4 || fidx == 5) q_left = {q_left[7:0], b};
				else if (fidx == 6 || fidx == 7) an_left = {an_left[7:0], b};
				else if (fidx == 8 || fidx == 9) au_left = mode_reg ? {au_left[7:0], b} : 16'd0;
				else if (fidx == 10 || fidx == 11)
					ad_left = mode_reg ? {ad_left[7:0], b} : 16'd0;
				if (fidx >= drts_pkg::HEADER_BYTES - 1) pick_section();
				else fidx++;
			end
			drts_pkg::PH_Q_LEN: name_byte(b, 1'b1);
			drts_pkg::PH_R_LEN: name_byte(b, 1'b0);
			drts_pkg::PH_Q_LABEL, drts_pkg::PH_R_LABEL: begin
				if (lab_left != 0) lab_left--;
				if (lab_left == 0)
					ph = (ph == drts_pkg::PH_Q_LABEL) ? drts_pkg::PH_Q_LEN : drts_pkg::PH_R_LEN;
			end
			drts_pkg::PH_Q_PTR: begin fidx = 0; ph = drts_pkg::PH_Q_FIX; end
			drts_pkg::PH_R_PTR: begin fidx = 0; ph = drts_pkg::PH_R_FIX; end
			drts_pkg::PH_Q_FIX: begin
				if (fidx >= 3) begin
					if (q_left != 0) q_left--;
					pick_section();
				end else fidx++;
			end
			drts_pkg::PH_R_FIX: begin
				if (fidx <= 1) rtype = {rtype[7:0], b};
				else if (fidx >= 4 && fidx <= 7) begin
					ttl_acc = {ttl_acc[23:0], b};
					if (rtype != drts_pkg::TYPE_OPT) begin
						if (mode_reg) ob = 8'(repl_ttl >> ((7 - fidx) * 8));
						if (fidx == 7) begin
							if (seen != drts_pkg::SEEN_MAX) seen++;
							if (ttl_acc < least_ttl) least_ttl = ttl_acc;
						end
					end
				end else if (fidx >= 8) rd_left = {rd_left[7:0], b};
				if (fidx >= 9) begin
					fidx = 0;
					if (rd_left == 0) close_record();
					else ph = drts_pkg::PH_R_DATA;
				end else fidx++;
			end
			drts_pkg::PH_R_DATA: begin
				if (rd_left != 0) rd_left--;
				if (rd_left == 0) close_record();
			end
			drts_pkg::PH_TRAIL: ;
			default: ph = drts_pkg::PH_ERR;
		endcase
		e = '0;
		e.data = ob;
		expected_beats.insert(expected_beats.size(), e);
		if (last) begin
			e = '0;
			e.kind = 1; e.last = 1; e.least = least_ttl; e.cnt = seen;
			if (err || ph != drts_pkg::PH_TRAIL) e.st = drts_pkg::ST_BAD;
			else if (mode_reg) e.st = drts_pkg::ST_OK;
			else if (seen == 0) e.st = drts_pkg::ST_NONE;
			else if (least_ttl == 0) e.st = drts_pkg::ST_ZERO;
			else e.st = drts_pkg::ST_OK;
			expected_beats.insert(expected_beats.size(), e);
			clear_parser();
		end
	endfunction

	// message builders
	function automatic void put(logic [7:0] b);
		pending_bytes.insert(pending_bytes.size(), byte_beat_t'({b, 1'b0}));
	endfunction

	function automatic void put16(logic [15:0] v);
		put(v[15:8]); put(v[7:0]);
	endfunction

	function automatic void end_message();
		byte_beat_t t;
		if (pending_bytes.size() == 0) put(8'h00);
		t = pending_bytes[pending_bytes.size() - 1];
		t.last = 1'b1;
		pending_bytes[pending_bytes.size() - 1] = t;
	endfunction

	function automatic void put_name();
		int n;
		n = $urandom_range(0, 2);
		repeat (n) begin
			int l;
			l = $urandom_range(1, 4);
			put(l[7:0]);
			repeat (l) put(8'($urandom));
		end
		if ($urandom_range(0, 2) == 0) begin
			put(8'hC0 | 8'($urandom_range(0, 63))); put(8'($urandom));
		end else put(8'h00);
	endfunction

	function automatic void put_record(bit opt, logic [31:0] ttl);
		int rl;
		put_name();
		put16(opt ? drts_pkg::TYPE_OPT : 16'($urandom_range(1, 60)));
		put16(16'($urandom));
		put16(ttl[31:16]); put16(ttl[15:0]);
		rl = $urandom_range(0, 4);
		put16(rl[15:0]);
		repeat (rl) put(8'($urandom));
	endfunction

	function automatic logic [31:0] rand_ttl();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// well-formed message with random content, optionally broken
	function automatic void put_message(int q, int an, int au, int ad, int breakage);
		put16(16'($urandom)); put16(16'($urandom));
		put16(q[15:0]); put16(an[15:0]); put16(au[15:0]); put16(ad[15:0]);
		repeat (q) begin
			put_name(); put16(16'($urandom)); put16(16'($urandom));
		end
		repeat (an + au + ad) put_record($urandom_range(0, 7) == 0, rand_ttl());
		if (breakage == 1) put(8'h40 | 8'($urandom_range(0, 63)));
		if (breakage == 2) put(8'h80 | 8'($urandom_range(0, 63)));
		if (breakage == 3 && pending_bytes.size() > 3) begin
			pending_bytes.delete(pending_bytes.size() - 1);
			pending_bytes.delete(pending_bytes.size() - 1);
		end
		repeat ($urandom_range(0, 2)) put(8'($urandom));
		end_message();
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (in_valid && in_ready) predict_byte(data_byte, is_last_in);
		if (!in_valid || in_ready) begin
			if (send_gap > 0 || pending_bytes.size() == 0 || !arst_n || feed_done) begin
				in_valid <= 1'b0;
				if (send_gap > 0) send_gap <= send_gap - 1;
			end else begin
				byte_beat_t t;
				t = pending_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= t.data;
				is_last_in <= t.last;
				send_gap <= gap_len();
			end
		end
	end

	// monitor and receiver stalls
	int recv_gap = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			scan_beat_t got, e;
			got = {item_kind, out_byte, status, min_ttl, ttl_count, is_last_out};
			if (expected_beats.size() == 0) begin
				stray_count++;
				if (mismatch_count + stray_count <= 10)
					$display("unexpected beat %h", got);
			end else begin
				e = expected_beats.pop_front();
				if (got !== e) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp kind %b byte %h st %0d min %h cnt %0d last %b,",
							e.kind, e.data, e.st, e.least, e.cnt, e.last,
							" got kind %b byte %h st %0d min %h cnt %0d last %b",
							got.kind, got.data, got.st, got.least, got.cnt, got.last);
				end
			end
		end
		if (stall_hold) out_ready <= 1'b0;
		else if (recv_gap > 0) begin
			out_ready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			out_ready <= 1'b1;
			recv_gap <= gap_len();
		end
	end

	// long receiver hold-off so the beat queue fills and input stalls
	initial begin
		wait (cycle_count == 3000);
		stall_hold = 1'b1;
		repeat (200) @(posedge clk);
		stall_hold = 1'b0;
	end

	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == drts_pkg::REG_MODE) mode_reg = val[0];
		else repl_ttl = val;
	endtask

	task automatic drain();
		wait (pending_bytes.size() == 0 && !in_valid && expected_beats.size() == 0);
		repeat (5) @(posedge clk);
	endtask

	// timeout
	always @(posedge clk) begin
		if (cycle_count > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int settings [4];
		int total;
		clear_parser();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, each broken case, trailing bytes
		put_message(1, 2, 0, 0, 0);
		put_message(0, 0, 0, 0, 0);
		put_message(1, 1, 0, 0, 1);
		put_message(0, 1, 0, 0, 2);
		put_message(2, 2, 0, 0, 3);
		put(8'hFF); end_message();
		put16(16'hFFFF); put16(16'hFFFF); put16(16'h0000); put16(16'h0001);
		put16(16'd0); put16(16'd0);
		put(8'h00); put16(16'd1); put16(16'd1); put16(16'd0); put16(16'd0); put16(16'd0);
		put(8'hAA);
		end_message();
		put_message(0, 1, 0, 0, 0);
		drain();
		write_reg(drts_pkg::REG_MODE, 32'd1);
		write_reg(drts_pkg::REG_TTL, 32'hFFFF_FFFF);
		put_message(1, 1, 1, 1, 0);
		put_message(0, 1, 1, 2, 2);
		drain();
		write_reg(drts_pkg::REG_TTL, 32'h0);
		put_message(1, 2, 1, 1, 0);
		drain();
		// random phases over several register settings
		settings[0] = 0; settings[1] = 1; settings[2] = 1; settings[3] = 0;
		total = 0;
		for (int p = 0; p < 4; p++) begin
			write_reg(drts_pkg::REG_MODE, settings[p]);
			write_reg(drts_pkg::REG_TTL, (p == 2) ? 32'h8000_0001 : $urandom);
			while (pending_bytes.size() < 200) begin
				int r;
				r = $urandom_range(0, 9);
				if (r < 7) put_message($urandom_range(0, 2), $urandom_range(0, 3),
					$urandom_range(0, 2), $urandom_range(0, 2), 0);
				else if (r < 9) put_message($urandom_range(0, 2), $urandom_range(0, 2),
					$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(1, 3));
				else begin
					repeat ($urandom_range(1, 20)) put(8'($urandom));
					end_message();
				end
			end
			drain();
		end
		feed_done = 1'b1;
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && stray_count == 0 && expected_beats.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
